FILE: design/csmp_pkg.sv
package csmp_pkg;

	// Frame geometry
	localparam int FFT_SIZE      = 20;
	localparam int HOP           = 5;
	localparam int HISTORY_DEPTH = 32;
	localparam int COUNT_BITS    = 20;
	localparam int NUM_BINS      = FFT_SIZE / 2 + 1;
	localparam int PAD           = FFT_SIZE / 2;
	localparam int LEAD_DEPTH    = PAD + 1;
	localparam int NEED_OFF      = FFT_SIZE - 1 - PAD;

	// CORDIC constants, angles in Q.16 radians
	localparam int    CORDIC_STEPS    = 16;
	localparam int    ANG_PI          = 205887;
	localparam int    ANG_HALF_PI     = 102944;
	localparam int    ANG_TWO_PI      = 411775;
	localparam longint CORDIC_GAIN_Q30 = 652032874;
	localparam int    GAIN_SPLIT      = 15;
	localparam int    GAIN_HI         = int'(CORDIC_GAIN_Q30 >> GAIN_SPLIT);
	localparam int    GAIN_LO         = int'(CORDIC_GAIN_Q30 % (64'd1 << GAIN_SPLIT));
	localparam int    PHASE_LIMIT     = 25736;
	localparam int    MAG_LIMIT       = 655360;

	// Datapath widths
	localparam int SMP_W     = 16;
	localparam int TW_W      = 17;
	localparam int WIN_W     = 18;
	localparam int OPA_W     = 34;
	localparam int PROD_W    = OPA_W + WIN_W;
	localparam int V_W       = 33;
	localparam int ACC_W     = 53;
	localparam int RND_SHIFT = 22;
	localparam int CXY_W     = ACC_W - RND_SHIFT;
	localparam int XW        = 34;
	localparam int ZW        = 20;
	localparam int MAGACC_W  = PROD_W + GAIN_SPLIT + 1;
	localparam int MAG_SHIFT = 38;
	localparam int MAG_W     = 20;
	localparam int PH_W      = 16;
	localparam int BIN_W     = $clog2(NUM_BINS);
	localparam int K_W       = $clog2(FFT_SIZE);
	localparam int CNT_W     = $clog2(2 * FFT_SIZE + 1);
	localparam int HIST_AW   = $clog2(HISTORY_DEPTH);
	localparam int LEAD_AW   = $clog2(LEAD_DEPTH);
	localparam int POS_W     = COUNT_BITS + 3;
	localparam int STEP_W    = $clog2(CORDIC_STEPS);

	localparam int ATAN_TAB [CORDIC_STEPS] = '{
		51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2
	};

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHECK, ST_WIN, ST_WWAIT, ST_DFT, ST_DWAIT, ST_ROUND,
		ST_CSTART, ST_CWAIT, ST_MAG, ST_MWAIT, ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		DST_V, DST_RE, DST_IM, DST_MHI, DST_MLO
	} dst_t;

	// Twiddles by CORDIC rotation, worked out at elaboration
	function automatic logic [2*FFT_SIZE*TW_W-1:0] build_twiddles();
		logic [2*FFT_SIZE*TW_W-1:0] tab;
		longint z, x, y, dx, dy, c, s;
		bit neg;
		tab = '0;
		for (int m = 0; m < FFT_SIZE; m++) begin
			z = longint'(m) * ANG_TWO_PI / FFT_SIZE;
			x = CORDIC_GAIN_Q30;
			y = 0;
			neg = 1'b0;
			if (z > ANG_PI)
				z = z - ANG_TWO_PI;
			if (z > ANG_HALF_PI) begin
				z = z - ANG_PI;
				neg = 1'b1;
			end else if (z < -ANG_HALF_PI) begin
				z = z + ANG_PI;
				neg = 1'b1;
			end
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x - dx;
					y = y + dy;
					z = z - ATAN_TAB[i];
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + ATAN_TAB[i];
				end
			end
			c = (x + 16384) >>> 15;
			s = (y + 16384) >>> 15;
			if (neg) begin
				c = -c;
				s = -s;
			end
			if (c > 32768) c = 32768;
			if (c < -32768) c = -32768;
			if (s > 32768) s = 32768;
			if (s < -32768) s = -32768;
			tab[(2*m)*TW_W +: TW_W]   = c[TW_W-1:0];
			tab[(2*m+1)*TW_W +: TW_W] = s[TW_W-1:0];
		end
		return tab;
	endfunction

	localparam logic [2*FFT_SIZE*TW_W-1:0] TWIDDLES = build_twiddles();

	function automatic logic signed [TW_W-1:0] tw_cos(input logic [K_W-1:0] m);
		return $signed(TWIDDLES[(2*m)*TW_W +: TW_W]);
	endfunction

	function automatic logic signed [TW_W-1:0] tw_sin(input logic [K_W-1:0] m);
		return $signed(TWIDDLES[(2*m+1)*TW_W +: TW_W]);
	endfunction

	// Periodic Hann weight, Q0.16
	function automatic logic signed [WIN_W-1:0] win_coef(input logic [K_W-1:0] k);
		logic signed [TW_W-1:0] c;
		c = tw_cos(k);
		return WIN_W'(32768) - WIN_W'(c);
	endfunction

endpackage

FILE: design/csmp_cordic.sv
module csmp_cordic import csmp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [CXY_W-1:0] x_in,
	input  logic signed [CXY_W-1:0] y_in,
	output logic                    done,
	output logic signed [XW-1:0]    x_out,
	output logic signed [ZW-1:0]    z_out
);

	logic signed [XW-1:0] x_q, y_q, dx, dy;
	logic signed [ZW-1:0] z_q, at;
	logic [STEP_W-1:0]    step_q;
	logic                 busy_q, done_q;

	// Shared shifter and angle step
	always_comb begin
		dx = y_q >>> step_q;
		dy = x_q >>> step_q;
		at = ZW'(ATAN_TAB[step_q]);
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Vectoring: fold into the right half-plane, then rotate y to zero
	always_ff @(posedge clk) begin
		if (start) begin
			if (x_in < 0) begin
				x_q <= -XW'(x_in);
				y_q <= -XW'(y_in);
				z_q <= (y_in >= 0) ? ZW'(ANG_PI) : -ZW'(ANG_PI);
			end else begin
				x_q <= XW'(x_in);
				y_q <= XW'(y_in);
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end
		end
	end

	assign done  = done_q;
	assign x_out = x_q;
	assign z_out = z_q;

endmodule

FILE: design/centered_stft_mag_phase.sv
// Centered STFT, magnitude and phase. Each accepted sample is stored; whenever
// the samples for a 20-point frame (hop 5, periodic Hann, reflect padding of 10)
// are in, the block emits 11 items, one per bin 0..10, with magnitude (Q4.16)
// and phase (Q3.13). On a sample flagged final, or on the one that fills the
// sample counter, it emits all remaining frames, the last bin of the last frame
// carrying signal_done, and starts a new signal. All arithmetic runs through one
// 34x18 multiplier and one CORDIC unit under a sequencer; in_stall is high
// from acceptance until the sequencer, having loaded the last item of that
// sample into the output register, is idle again. Each frame is a windowing
// pass and then, per bin, 40 multiplies, 16 CORDIC steps, rounding and
// magnitude scaling. A final sample may emit up to three frames. Output
// stalls hold the sequencer until the output register is free.
module centered_stft_mag_phase import csmp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [SMP_W-1:0] sample,
	input  logic                    final_sample,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [BIN_W-1:0]        bin_index,
	output logic [MAG_W-1:0]        magnitude,
	output logic signed [PH_W-1:0]  phase_angle,
	output logic                    frame_done,
	output logic                    signal_done
);

	localparam logic signed [ACC_W-1:0]    RND_HALF = ACC_W'(1) <<< (RND_SHIFT - 1);
	localparam logic signed [MAGACC_W-1:0] MAG_HALF = MAGACC_W'(1) <<< (MAG_SHIFT - 1);

	state_t state_q, state_d;

	logic signed [SMP_W-1:0] hist_q [HISTORY_DEPTH];
	logic signed [SMP_W-1:0] lead_q [LEAD_DEPTH];
	logic signed [V_W-1:0]   v_q [FFT_SIZE];

	logic [COUNT_BITS-1:0] seen_q;
	logic [POS_W-1:0]      off_q;
	logic                  final_q, last_q;
	logic [BIN_W-1:0]      bin_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [K_W-1:0]        m_q, m_next;
	logic [K_W:0]          m_sum;

	logic signed [ACC_W-1:0]    re_q, im_q;
	logic signed [CXY_W-1:0]    cx_q, cy_q, rnd_re, rnd_im;
	logic                       zero_q;
	logic signed [MAGACC_W-1:0] magacc_q, mag_sh;

	// Multiplier pipeline
	logic                    v_s1, v_s2, v_s3;
	logic [COUNT_BITS-1:0]   idx_s1;
	logic [K_W-1:0]          k_s1, k_s2, k_s3;
	logic signed [OPA_W-1:0] opa_s2;
	logic signed [WIN_W-1:0] opb_s2;
	dst_t                    dst_s2, dst_s3;
	logic signed [PROD_W-1:0] prod_s3;

	logic                    iss_v;
	logic signed [OPA_W-1:0] iss_a;
	logic signed [WIN_W-1:0] iss_b;
	dst_t                    iss_dst;
	logic [K_W-1:0]          iss_k;
	logic signed [SMP_W-1:0] smp_rd;

	logic signed [POS_W-1:0] sp, sn, lv, rv, iv;
	logic [POS_W-1:0]        n_ext;

	logic in_acc, out_free, pipe_empty, frame_go, bin_last;
	logic cord_start, cord_done;
	logic signed [XW-1:0] cord_x;
	logic signed [ZW-1:0] cord_z, ph_sh;
	logic [MAG_W-1:0]        mag_val;
	logic signed [PH_W-1:0]  ph_val;
	logic                    ov_q;

	csmp_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.x_in   (cx_q),
		.y_in   (cy_q),
		.done   (cord_done),
		.x_out  (cord_x),
		.z_out  (cord_z)
	);

	// Handshake and frame decisions
	always_comb begin
		in_acc     = in_valid && (state_q == ST_IDLE);
		out_free   = !ov_q || !out_stall;
		pipe_empty = !(v_s1 || v_s2 || v_s3);
		bin_last   = (bin_q == BIN_W'(NUM_BINS - 1));
		n_ext      = POS_W'(seen_q);
		if (final_q)
			frame_go = (off_q <= n_ext);
		else
			frame_go = (off_q + POS_W'(NEED_OFF + 1) <= n_ext) &&
				(n_ext >= POS_W'(PAD + 1));
		m_sum  = {1'b0, m_q} + (K_W+1)'(bin_q);
		m_next = (m_sum >= (K_W+1)'(FFT_SIZE)) ? K_W'(m_sum - (K_W+1)'(FFT_SIZE))
			: K_W'(m_sum);
	end

	// Padded index of the frame position, with reflection and short-signal clamps
	always_comb begin
		sp = $signed(off_q + POS_W'(cnt_q));
		sn = $signed(n_ext);
		lv = POS_W'(PAD) - sp;
		if (lv > sn - POS_W'(1))
			lv = sn - POS_W'(1);
		rv = (sn <<< 1) - sp + POS_W'(PAD - 2);
		if (rv < 0)
			rv = '0;
		if (sp < POS_W'(PAD))
			iv = lv;
		else if (sp >= sn + POS_W'(PAD))
			iv = rv;
		else
			iv = sp - POS_W'(PAD);
	end

	// Sample fetch for the windowing pass
	always_comb begin
		if (idx_s1 < COUNT_BITS'(LEAD_DEPTH))
			smp_rd = lead_q[idx_s1[LEAD_AW-1:0]];
		else
			smp_rd = hist_q[idx_s1[HIST_AW-1:0]];
	end

	// Operand issue for DFT and magnitude scaling
	always_comb begin
		iss_v   = 1'b0;
		iss_k   = K_W'(cnt_q >> 1);
		iss_a   = OPA_W'(v_q[iss_k]);
		iss_b   = cnt_q[0] ? WIN_W'(tw_sin(m_q)) : WIN_W'(tw_cos(m_q));
		iss_dst = cnt_q[0] ? DST_IM : DST_RE;
		case (state_q)
			ST_DFT: iss_v = 1'b1;
			ST_MAG: begin
				iss_v   = 1'b1;
				iss_a   = OPA_W'(cord_x);
				iss_b   = cnt_q[0] ? WIN_W'(GAIN_LO) : WIN_W'(GAIN_HI);
				iss_dst = cnt_q[0] ? DST_MLO : DST_MHI;
			end
			default: iss_v = 1'b0;
		endcase
	end

	// Rounding, scaling and clamps
	always_comb begin
		rnd_re  = CXY_W'((re_q + RND_HALF) >>> RND_SHIFT);
		rnd_im  = CXY_W'((im_q + RND_HALF) >>> RND_SHIFT);
		mag_sh  = (magacc_q + MAG_HALF) >>> MAG_SHIFT;
		if (mag_sh < 0)
			mag_val = '0;
		else if (mag_sh > MAGACC_W'(MAG_LIMIT))
			mag_val = MAG_W'(MAG_LIMIT);
		else
			mag_val = mag_sh[MAG_W-1:0];
		ph_sh = (cord_z + ZW'(4)) >>> 3;
		if (zero_q)
			ph_val = '0;
		else if (ph_sh > ZW'(PHASE_LIMIT))
			ph_val = PH_W'(PHASE_LIMIT);
		else if (ph_sh < -ZW'(PHASE_LIMIT))
			ph_val = -PH_W'(PHASE_LIMIT);
		else
			ph_val = ph_sh[PH_W-1:0];
	end

	// Sequencer next state
	always_comb begin
		state_d    = state_q;
		cord_start = 1'b0;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_CHECK;
			ST_CHECK:  state_d = frame_go ? ST_WIN : ST_IDLE;
			ST_WIN:    if (cnt_q == CNT_W'(FFT_SIZE - 1)) state_d = ST_WWAIT;
			ST_WWAIT:  if (pipe_empty) state_d = ST_DFT;
			ST_DFT:    if (cnt_q == CNT_W'(2 * FFT_SIZE - 1)) state_d = ST_DWAIT;
			ST_DWAIT:  if (pipe_empty) state_d = ST_ROUND;
			ST_ROUND:  state_d = ST_CSTART;
			ST_CSTART: begin
				cord_start = 1'b1;
				state_d    = ST_CWAIT;
			end
			ST_CWAIT:  if (cord_done) state_d = ST_MAG;
			ST_MAG:    if (cnt_q == CNT_W'(1)) state_d = ST_MWAIT;
			ST_MWAIT:  if (pipe_empty) state_d = ST_OUT;
			ST_OUT:    if (out_free) state_d = bin_last ? ST_CHECK : ST_DFT;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Counters and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			off_q   <= '0;
			final_q <= 1'b0;
			last_q  <= 1'b0;
			bin_q   <= '0;
			cnt_q   <= '0;
			m_q     <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_WIN);
			v_s2 <= v_s1 || iss_v;
			v_s3 <= v_s2;
			// Raise valid on a new item, drop it once taken
			if (state_q == ST_OUT && out_free)
				ov_q <= 1'b1;
			else if (!out_stall)
				ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_acc) begin
					seen_q  <= seen_q + 1'b1;
					final_q <= final_sample ||
						(seen_q == {{(COUNT_BITS-1){1'b1}}, 1'b0});
				end
				ST_CHECK: begin
					cnt_q <= '0;
					if (frame_go) begin
						last_q <= final_q && (off_q + POS_W'(HOP) > n_ext);
					end else if (final_q) begin
						seen_q  <= '0;
						off_q   <= '0;
						final_q <= 1'b0;
					end
				end
				ST_WIN: cnt_q <= cnt_q + 1'b1;
				ST_WWAIT: begin
					bin_q <= '0;
					cnt_q <= '0;
					m_q   <= '0;
				end
				ST_DFT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q[0])
						m_q <= m_next;
				end
				ST_CWAIT: cnt_q <= '0;
				ST_MAG: cnt_q <= cnt_q + 1'b1;
				ST_OUT: if (out_free) begin
					cnt_q <= '0;
					m_q   <= '0;
					if (bin_last)
						off_q <= off_q + POS_W'(HOP);
					else
						bin_q <= bin_q + 1'b1;
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Sample stores
	always_ff @(posedge clk) begin
		if (in_acc) begin
			hist_q[seen_q[HIST_AW-1:0]] <= sample;
			if (seen_q < COUNT_BITS'(LEAD_DEPTH))
				lead_q[seen_q[LEAD_AW-1:0]] <= sample;
		end
	end

	// Multiplier pipeline: index, operands, product
	always_ff @(posedge clk) begin
		idx_s1 <= iv[COUNT_BITS-1:0];
		k_s1   <= K_W'(cnt_q);
		if (v_s1) begin
			opa_s2 <= OPA_W'(smp_rd);
			opb_s2 <= win_coef(k_s1);
			dst_s2 <= DST_V;
			k_s2   <= k_s1;
		end else begin
			opa_s2 <= iss_a;
			opb_s2 <= iss_b;
			dst_s2 <= iss_dst;
			k_s2   <= iss_k;
		end
		prod_s3 <= opa_s2 * opb_s2;
		dst_s3  <= dst_s2;
		k_s3    <= k_s2;
	end

	// Accumulate products; clear sums at the start of each pass
	always_ff @(posedge clk) begin
		if ((state_q == ST_WWAIT && pipe_empty) || (state_q == ST_OUT && out_free)) begin
			re_q <= '0;
			im_q <= '0;
		end
		if (state_q == ST_CWAIT)
			magacc_q <= '0;
		if (state_q == ST_ROUND) begin
			cx_q   <= rnd_re;
			cy_q   <= rnd_im;
			zero_q <= (rnd_re == '0) && (rnd_im == '0);
		end
		if (v_s3) begin
			case (dst_s3)
				DST_V:   v_q[k_s3] <= prod_s3[V_W-1:0];
				DST_RE:  re_q <= re_q + ACC_W'(prod_s3);
				DST_IM:  im_q <= im_q - ACC_W'(prod_s3);
				DST_MHI: magacc_q <= magacc_q + (MAGACC_W'(prod_s3) <<< GAIN_SPLIT);
				DST_MLO: magacc_q <= magacc_q + MAGACC_W'(prod_s3);
				default: magacc_q <= magacc_q;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			bin_index   <= bin_q;
			magnitude   <= mag_val;
			phase_angle <= ph_val;
			frame_done  <= bin_last;
			signal_done <= bin_last && last_q;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = ov_q;

endmodule

FILE: tb/tb_centered_stft_mag_phase.sv
module tb_centered_stft_mag_phase;
	import csmp_pkg::*;

	typedef struct {
		logic [BIN_W-1:0]       bin;
		logic [MAG_W-1:0]       mag;
		logic signed [PH_W-1:0] ph;
		logic                   fdone;
		logic                   sdone;
	} bin_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic signed [SMP_W-1:0] sample = '0;
	logic                    final_sample = 1'b0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [BIN_W-1:0]        bin_index;
	logic [MAG_W-1:0]        magnitude;
	logic signed [PH_W-1:0]  phase_angle;
	logic                    frame_done;
	logic                    signal_done;

	// predictor state
	longint      cos_q15 [FFT_SIZE];
	longint      sin_q15 [FFT_SIZE];
	shortint     hist_store [HISTORY_DEPTH];
	shortint     lead_store [LEAD_DEPTH];
	longint      n_seen = 0;
	longint      n_frames_out = 0;
	bin_result_t expected_bins [$];

	int errors = 0;
	int samples_sent = 0;
	int bins_checked = 0;
	int frames_checked = 0;
	int signals_checked = 0;

	// receiver control
	bit rx_quiet = 1'b0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int stall_left = 0;

	centered_stft_mag_phase dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample       (sample),
		.final_sample (final_sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.bin_index    (bin_index),
		.magnitude    (magnitude),
		.phase_angle  (phase_angle),
		.frame_done   (frame_done),
		.signal_done  (signal_done)
	);

	always #10 clk = ~clk;

	// Build twiddles by CORDIC rotation
	function automatic void make_twiddles();
		longint z, x, y, dx, dy, c, s;
		bit neg;
		for (int m = 0; m < FFT_SIZE; m++) begin
			z = longint'(m) * ANG_TWO_PI / FFT_SIZE;
			x = CORDIC_GAIN_Q30;
			y = 0;
			neg = 1'b0;
			if (z > ANG_PI)
				z -= ANG_TWO_PI;
			if (z > ANG_HALF_PI) begin
				z -= ANG_PI;
				neg = 1'b1;
			end else if (z < -ANG_HALF_PI) begin
				z += ANG_PI;
				neg = 1'b1;
			end
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= ATAN_TAB[i];
				end else begin
					x += dx; y -= dy; z += ATAN_TAB[i];
				end
			end
			c = (x + 16384) >>> 15;
			s = (y + 16384) >>> 15;
			if (neg) begin
				c = -c;
				s = -s;
			end
			cos_q15[m] = (c > 32768) ? 32768 : ((c < -32768) ? -32768 : c);
			sin_q15[m] = (s > 32768) ? 32768 : ((s < -32768) ? -32768 : s);
		end
	endfunction

	function automatic longint stored_sample(longint idx);
		if (idx < 0)
			idx = 0;
		if (idx < LEAD_DEPTH)
			return lead_store[idx];
		return hist_store[idx % HISTORY_DEPTH];
	endfunction

	// Reflect padding with the short-signal clamps
	function automatic longint padded_sample(longint p, longint n);
		longint i;
		if (p < PAD) begin
			i = PAD - p;
			if (i > n - 1)
				i = n - 1;
		end else if (p >= PAD + n) begin
			i = 2 * n - 2 - p + PAD;
			if (i < 0)
				i = 0;
		end else begin
			i = p - PAD;
		end
		return stored_sample(i);
	endfunction

	function automatic void to_polar(longint x, longint y, output longint mag,
			output longint ph);
		longint z, dx, dy;
		z = 0;
		if (x == 0 && y == 0) begin
			mag = 0;
			ph = 0;
			return;
		end
		if (x < 0) begin
			z = (y >= 0) ? ANG_PI : -ANG_PI;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += ATAN_TAB[i];
			end else begin
				x -= dx; y += dy; z -= ATAN_TAB[i];
			end
		end
		mag = (x * CORDIC_GAIN_Q30 + (64'sd1 <<< 37)) >>> 38;
		if (mag < 0) mag = 0;
		if (mag > MAG_LIMIT) mag = MAG_LIMIT;
		ph = (z + 4) >>> 3;
		if (ph > PHASE_LIMIT) ph = PHASE_LIMIT;
		if (ph < -PHASE_LIMIT) ph = -PHASE_LIMIT;
	endfunction

	// Queue the 11 bins of one frame
	function automatic void queue_frame(longint t, longint n, bit last);
		longint      re, im, v, mag, ph;
		int          m;
		bin_result_t r;
		for (int f = 0; f < NUM_BINS; f++) begin
			re = 0;
			im = 0;
			for (int k = 0; k < FFT_SIZE; k++) begin
				v = padded_sample(t * HOP + k, n) * (32768 - cos_q15[k]);
				m = (f * k) % FFT_SIZE;
				re += v * cos_q15[m];
				im -= v * sin_q15[m];
			end
			to_polar((re + (64'sd1 <<< 21)) >>> 22, (im + (64'sd1 <<< 21)) >>> 22, mag, ph);
			r.bin = BIN_W'(f);
			r.mag = mag[MAG_W-1:0];
			r.ph = ph[PH_W-1:0];
			r.fdone = (f == NUM_BINS - 1);
			r.sdone = last && (f == NUM_BINS - 1);
			expected_bins.push_back(r);
		end
	endfunction

	// Advance the predictor by one accepted sample
	function automatic void predict_sample(shortint val, bit fin);
		longint total;
		bit     is_final;
		if (n_seen < LEAD_DEPTH)
			lead_store[n_seen] = val;
		hist_store[n_seen % HISTORY_DEPTH] = val;
		n_seen++;
		is_final = fin || (n_seen >= (64'd1 << COUNT_BITS) - 1);
		if (is_final) begin
			total = n_seen / HOP + 1;
			for (longint t = n_frames_out; t < total; t++)
				queue_frame(t, n_seen, t == total - 1);
			n_seen = 0;
			n_frames_out = 0;
		end else begin
			while (n_frames_out * HOP + NEED_OFF <= n_seen - 1 && PAD <= n_seen - 1) begin
				queue_frame(n_frames_out, n_seen, 1'b0);
				n_frames_out++;
			end
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one item and hold it until accepted
	task automatic send_sample(shortint val, bit fin, bit no_gap = 1'b0);
		int gap;
		gap = (no_gap || rx_quiet) ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= val;
		final_sample <= fin;
		do @(posedge clk); while (in_stall);
		predict_sample(val, fin);
		samples_sent++;
	endtask

	task automatic send_signal(int len, int amp_sel);
		shortint v;
		for (int i = 0; i < len; i++) begin
			case (amp_sel)
				0: v = shortint'($urandom);
				1: v = shortint'($urandom_range(0, 511) - 256);
				default: v = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
			endcase
			send_sample(v, i == len - 1);
		end
	endtask

	// Output side: check each accepted result
	always @(posedge clk) begin
		bin_result_t e;
		if (out_valid && !out_stall) begin
			if (expected_bins.size() == 0) begin
				errors++;
				$display("%0t: unexpected result bin %0d mag %0d phase %0d", $time,
					bin_index, magnitude, phase_angle);
			end else begin
				e = expected_bins.pop_front();
				bins_checked++;
				if (frame_done) frames_checked++;
				if (signal_done) signals_checked++;
				if (bin_index !== e.bin) begin
					errors++;
					$display("%0t: bin_index expected %0d actual %0d", $time, e.bin, bin_index);
				end
				if (magnitude !== e.mag) begin
					errors++;
					$display("%0t: magnitude (bin %0d) expected %0d actual %0d", $time, e.bin,
						e.mag, magnitude);
				end
				if (phase_angle !== e.ph) begin
					errors++;
					$display("%0t: phase_angle (bin %0d) expected %0d actual %0d", $time,
						e.bin, e.ph, phase_angle);
				end
				if (frame_done !== e.fdone) begin
					errors++;
					$display("%0t: frame_done expected %0b actual %0b", $time, e.fdone,
						frame_done);
				end
				if (signal_done !== e.sdone) begin
					errors++;
					$display("%0t: signal_done expected %0b actual %0b", $time, e.sdone,
						signal_done);
				end
			end
		end
	end

	// Output side: stall pattern, with long hold-offs on request
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 3000;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= (hold_left > 1);
		end else if (rx_quiet) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if ($urandom_range(0, 99) < 30)
				stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(15, 50) :
					$urandom_range(1, 3);
		end
	end

	// Single-, two- and three-sample signals, where padding indices clamp
	task automatic test_short_signals();
		send_sample(16'sh7fff, 1'b1);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7fff, 1'b1);
		send_sample(16'sh0001, 1'b0);
		send_sample(-16'sh0001, 1'b0);
		send_sample(16'sh5555, 1'b1);
	endtask

	// Silent signal gives zero bins
	task automatic test_zero_bins();
		for (int i = 0; i < 6; i++)
			send_sample(16'sh0000, i == 5);
	endtask

	// Full-scale square wave alternating between the extremes
	task automatic test_extremes();
		for (int i = 0; i < 13; i++)
			send_sample((i % 4 < 2) ? 16'sh7fff : 16'sh8000, i == 12);
	endtask

	// Receiver holds off while the sender keeps offering
	task automatic test_backpressure();
		hold_req++;
		for (int i = 0; i < 30; i++)
			send_sample(shortint'($urandom), i == 29, 1'b1);
	endtask

	// Random signals, mostly moderate lengths, some with no idling at all
	task automatic test_random_signals();
		int len;
		while (samples_sent < 330) begin
			rx_quiet = ($urandom_range(0, 4) == 0);
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(13, 60);
			if ($urandom_range(0, 15) == 0)
				len = 110;
			send_signal(len, ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2));
		end
		rx_quiet = 1'b0;
	endtask

	initial begin
		make_twiddles();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_signals();
		test_zero_bins();
		test_extremes();
		test_backpressure();
		test_random_signals();
		in_valid <= 1'b0;
		while (expected_bins.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("Sent %0d samples; checked %0d bins in %0d frames over %0d signals.",
			samples_sent, bins_checked, frames_checked, signals_checked);
		$display("Covered clamped short signals, silence, full scale, long hold-off.");
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#60000000;
		$display("Timeout with %0d results outstanding", expected_bins.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
